### sv/brs_pkg.sv
// ============================================================================
// Bilinear resampler package
// Shared constants, codes and types for the bilinear image resampler.
// ============================================================================
`timescale 1ns / 1ps

package brs_pkg;

   // Frame store geometry and fixed-point format.
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FRAC_BITS  = 8;

   // Field widths.
   localparam int POS_W    = 8;
   localparam int SIZE_W   = 9;
   localparam int PIX_W    = 24;
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 3;

   // Source index widths and the four-bank frame store.
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int IDX_W      = (XW > YW) ? XW : YW;
   localparam int BANK_AW    = XW + YW - 2;
   localparam int BANK_DEPTH = 1 << BANK_AW;

   // Coordinate divider: dividend is pos * size with the fraction bits appended.
   localparam int PROD_W     = POS_W + SIZE_W;
   localparam int NUM_W      = PROD_W + FRAC_BITS;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W      = DIV_STAGES * DIV_STEPS;
   localparam int MAP_LAT    = DIV_STAGES + 2;

   // Fixed-point one and one half.
   localparam int ONE  = 1 << FRAC_BITS;
   localparam int HALF = 1 << (FRAC_BITS - 1);

   // Interpolation widths.
   localparam int WT_W     = FRAC_BITS + 1;
   localparam int UP_W     = CHAN_W + FRAC_BITS;
   localparam int SUM_W    = UP_W + WT_W;
   localparam int CHAN_MAX = (1 << CHAN_W) - 1;

   // Stream data widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = ((2 * POS_W + PIX_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((PIX_W + 2 * POS_W + 7) / 8) * 8;

   // Request kinds carried on tuser.
   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   // One mapped axis: base index, clamped neighbour and fraction between them.
   typedef struct packed {
      logic [IDX_W-1:0]     idx0;
      logic [IDX_W-1:0]     idx1;
      logic [FRAC_BITS-1:0] frac;
   } axis_pos_type;

   // The four neighbouring values of one byte channel.
   typedef struct packed {
      logic [CHAN_W-1:0] c00;
      logic [CHAN_W-1:0] c10;
      logic [CHAN_W-1:0] c01;
      logic [CHAN_W-1:0] c11;
   } corners_type;

endpackage

### sv/bilinear_image_resampler_top.sv
// ============================================================================
// Bilinear image resampler
// Load items fill a frame store with source pixels; sample items return the
// bilinearly interpolated output pixel at a destination column and row. One
// item is taken every clock cycle while the result side keeps up, and a
// sample's result passes through the product stage for position times size,
// 13 stages of the coordinate divider (two quotient bits per stage), one
// clamp stage, one frame store read from four parity banks, two interpolation
// stages in the three channel lanes and the output register. Loads travel
// down the same pipeline and write the store where samples read it, so every
// sample sees exactly the loads taken before it. Loads give no result. A full
// stall of the result side holds the whole pipeline. Sizes are to be written
// only while no item is in flight.
// ============================================================================
`timescale 1ns / 1ps

module bilinear_image_resampler_top (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // col [7:0], row [15:8], pixel_in [39:16]
   input  logic [brs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type [0]
   input  logic                               req_tuser,
   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pixel_out [23:0], out_col [31:24], out_row [39:32]
   output logic [brs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration writes.
   input  logic                               csr_we,
   input  brs_pkg::csr_index_type             csr_index,
   input  logic [brs_pkg::SIZE_W-1:0]         csr_wdata
);
   import brs_pkg::*;

   typedef struct packed {
      req_kind_type      kind;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      logic [PIX_W-1:0]  pixel;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]     col;
      logic [POS_W-1:0]     row;
      logic                 x0p;
      logic                 x1p;
      logic                 y0p;
      logic                 y1p;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
   } read_type;

   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } out_pos_type;

   logic [SIZE_W-1:0]           src_width_ff;
   logic [SIZE_W-1:0]           src_height_ff;
   logic [SIZE_W-1:0]           dst_width_ff;
   logic [SIZE_W-1:0]           dst_height_ff;
   logic [SIZE_W-1:0]           src_w_sat;
   logic [SIZE_W-1:0]           src_h_sat;
   logic [SIZE_W-1:0]           dst_w_sat;
   logic [SIZE_W-1:0]           dst_h_sat;
   logic                        en;
   item_type                    item_in;
   logic [MAP_LAT-1:0]          sb_valid_ff;
   item_type                    sb_ff [MAP_LAT];
   item_type                    st;
   logic                        st_valid;
   logic                        st_write;
   axis_pos_type                map_x;
   axis_pos_type                map_y;
   logic [1:0][1:0][PIX_W-1:0]  bank_data;
   logic                        r_valid_ff;
   read_type                    r_ff;
   read_type                    r_in;
   logic                        l1_valid_ff;
   logic                        l2_valid_ff;
   out_pos_type                 l1_pos_ff;
   out_pos_type                 l2_pos_ff;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] lane_chan;
   logic                        rsp_valid_ff;
   logic [PIX_W-1:0]            rsp_pixel_ff;
   out_pos_type                 rsp_pos_ff;

   // Saturates a size to 1..maxv, a zero counting as one.
   function automatic logic [SIZE_W-1:0] sat_size(logic [SIZE_W-1:0] v,
                                                  logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIZE_W'(256);
         src_height_ff <= SIZE_W'(256);
         dst_width_ff  <= SIZE_W'(28);
         dst_height_ff <= SIZE_W'(28);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign src_w_sat = sat_size(src_width_ff, SIZE_W'(MAX_WIDTH));
   assign src_h_sat = sat_size(src_height_ff, SIZE_W'(MAX_HEIGHT));
   assign dst_w_sat = sat_size(dst_width_ff, '1);
   assign dst_h_sat = sat_size(dst_height_ff, '1);

   // The whole pipeline advances whenever the output register is free.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Unpack the request item.
   assign item_in.kind  = req_kind_type'(req_tuser);
   assign item_in.col   = req_tdata[POS_W-1:0];
   assign item_in.row   = req_tdata[2*POS_W-1:POS_W];
   assign item_in.pixel = req_tdata[2*POS_W+PIX_W-1:2*POS_W];

   // Coordinate mapping, one unit per axis.
   brs_axis_map u_map_x (
      .clock    (clock),
      .en       (en),
      .pos      (item_in.col),
      .src_size (src_w_sat),
      .dst_size (dst_w_sat),
      .map_out  (map_x)
   );

   brs_axis_map u_map_y (
      .clock    (clock),
      .en       (en),
      .pos      (item_in.row),
      .src_size (src_h_sat),
      .dst_size (dst_h_sat),
      .map_out  (map_y)
   );

   // Item line that runs beside the mapping units.
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= '0;
      end else if (en) begin
         sb_valid_ff <= {sb_valid_ff[MAP_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= item_in;
         for (int k = 1; k < MAP_LAT; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   assign st       = sb_ff[MAP_LAT-1];
   assign st_valid = sb_valid_ff[MAP_LAT-1];
   assign st_write = st_valid && (st.kind == REQ_LOAD)
                     && (int'(st.col) < MAX_WIDTH) && (int'(st.row) < MAX_HEIGHT);

   // Frame store: loads write and samples read at the same stage.
   brs_frame_store u_store (
      .clock    (clock),
      .en       (en),
      .wr_en    (st_write),
      .wr_col   (XW'(st.col)),
      .wr_row   (YW'(st.row)),
      .wr_pixel (st.pixel),
      .rd_x0    (XW'(map_x.idx0)),
      .rd_y0    (YW'(map_y.idx0)),
      .rd_data  (bank_data)
   );

   // Read stage: keep the bank selects and fractions alongside the read.
   assign r_in.col = st.col;
   assign r_in.row = st.row;
   assign r_in.x0p = map_x.idx0[0];
   assign r_in.x1p = map_x.idx1[0];
   assign r_in.y0p = map_y.idx0[0];
   assign r_in.y1p = map_y.idx1[0];
   assign r_in.fx  = map_x.frac;
   assign r_in.fy  = map_y.frac;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         l1_valid_ff  <= 1'b0;
         l2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         r_valid_ff   <= st_valid && (st.kind == REQ_SAMPLE);
         l1_valid_ff  <= r_valid_ff;
         l2_valid_ff  <= l1_valid_ff;
         rsp_valid_ff <= l2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff          <= r_in;
         l1_pos_ff.col <= r_ff.col;
         l1_pos_ff.row <= r_ff.row;
         l2_pos_ff     <= l1_pos_ff;
      end
   end

   // Channel lanes, each fed from the banks that hold its four neighbours.
   for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
      corners_type corners;

      assign corners.c00 = bank_data[r_ff.y0p][r_ff.x0p][ch*CHAN_W +: CHAN_W];
      assign corners.c10 = bank_data[r_ff.y0p][r_ff.x1p][ch*CHAN_W +: CHAN_W];
      assign corners.c01 = bank_data[r_ff.y1p][r_ff.x0p][ch*CHAN_W +: CHAN_W];
      assign corners.c11 = bank_data[r_ff.y1p][r_ff.x1p][ch*CHAN_W +: CHAN_W];

      brs_lane u_lane (
         .clock    (clock),
         .en       (en),
         .corners  (corners),
         .frac_x   (r_ff.fx),
         .frac_y   (r_ff.fy),
         .chan_out (lane_chan[ch])
      );
   end

   // Merge the lanes into the output register.
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_pixel_ff <= PIX_W'(lane_chan);
         rsp_pos_ff   <= l2_pos_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_pos_ff.row, rsp_pos_ff.col, rsp_pixel_ff});

   // A load item never turns into a result.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      en && st_valid && (st.kind == REQ_LOAD) |=> !r_valid_ff)
      else $error("load item entered the result path");

   // The column neighbour is the base column or the one after it.
   a_x_neighbour: assert property (@(posedge clock) disable iff (reset)
      st_valid && (st.kind == REQ_SAMPLE)
      |-> (map_x.idx1 == map_x.idx0) || (map_x.idx1 == map_x.idx0 + IDX_W'(1)))
      else $error("column neighbour out of step with base column");

   // At the right edge the coordinate sits exactly on the last column.
   a_x_edge_frac: assert property (@(posedge clock) disable iff (reset)
      st_valid && (st.kind == REQ_SAMPLE) && (map_x.idx1 == map_x.idx0)
      |-> (map_x.frac == '0))
      else $error("non-zero column fraction at the right edge");

   // At the bottom edge the coordinate sits exactly on the last row.
   a_y_edge_frac: assert property (@(posedge clock) disable iff (reset)
      st_valid && (st.kind == REQ_SAMPLE) && (map_y.idx1 == map_y.idx0)
      |-> (map_y.frac == '0))
      else $error("non-zero row fraction at the bottom edge");

   // No result is offered straight after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

### sv/brs_axis_map.sv
// ============================================================================
// Bilinear resampler axis mapper
// Maps a destination position to a source index, its neighbour and the
// fraction between them through a pipelined restoring divider.
// ============================================================================
`timescale 1ns / 1ps

module brs_axis_map (
   input  logic                        clock,
   input  logic                        en,
   input  logic [brs_pkg::POS_W-1:0]   pos,
   input  logic [brs_pkg::SIZE_W-1:0]  src_size,
   input  logic [brs_pkg::SIZE_W-1:0]  dst_size,
   output brs_pkg::axis_pos_type       map_out
);
   import brs_pkg::*;

   typedef struct packed {
      logic [SIZE_W-1:0] rem;
      logic [DIV_W-1:0]  dq;
   } div_state_type;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   div_state_type     div_init;
   div_state_type     div_src [DIV_STAGES];
   div_state_type     div_ff [DIV_STAGES];
   div_state_type     div_in [DIV_STAGES];
   logic [SIZE_W-1:0] src_last;
   logic [DIV_W-1:0]  quot;
   logic [DIV_W-1:0]  top;
   logic [DIV_W-1:0]  g;
   axis_pos_type      map_ff;
   axis_pos_type      map_in;

   // One restoring division step: bring down a bit, subtract when it fits.
   function automatic div_state_type div_step(div_state_type st, logic [SIZE_W-1:0] dvs);
      div_state_type nx;
      logic [SIZE_W:0] trial;
      logic qbit;
      trial = {st.rem, st.dq[DIV_W-1]};
      if (trial >= {1'b0, dvs}) begin
         nx.rem = SIZE_W'(trial - {1'b0, dvs});
         qbit   = 1'b1;
      end else begin
         nx.rem = trial[SIZE_W-1:0];
         qbit   = 1'b0;
      end
      nx.dq = {st.dq[DIV_W-2:0], qbit};
      return nx;
   endfunction

   // Position times source size.
   assign prod_in = PROD_W'(pos) * PROD_W'(src_size);

   // Divider stages, two quotient bits each.
   assign div_init.rem = '0;
   assign div_init.dq  = DIV_W'({prod_ff, {FRAC_BITS{1'b0}}});

   // Each stage starts from the previous stage's register, the first from
   // the product.
   assign div_src[0] = div_init;
   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_src
      assign div_src[k] = div_ff[k-1];
   end

   always_comb begin
      div_state_type st;
      for (int k = 0; k < DIV_STAGES; k++) begin
         st = div_src[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            st = div_step(st, dst_size);
         end
         div_in[k] = st;
      end
   end

   // Remove the half-pixel offset, clamp to the source and split the result.
   always_comb begin
      src_last = src_size - SIZE_W'(1);
      quot     = div_ff[DIV_STAGES-1].dq;
      top      = DIV_W'({src_last, {FRAC_BITS{1'b0}}});
      if (quot < DIV_W'(HALF)) begin
         g = '0;
      end else begin
         g = quot - DIV_W'(HALF);
         if (g > top) begin
            g = top;
         end
      end
      map_in.idx0 = IDX_W'(g >> FRAC_BITS);
      map_in.frac = g[FRAC_BITS-1:0];
      if ((SIZE_W'(map_in.idx0) + SIZE_W'(1)) < src_size) begin
         map_in.idx1 = map_in.idx0 + IDX_W'(1);
      end else begin
         map_in.idx1 = IDX_W'(src_last);
      end
   end

   // Pipeline registers, all advancing together.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         for (int k = 0; k < DIV_STAGES; k++) begin
            div_ff[k] <= div_in[k];
         end
         map_ff <= map_in;
      end
   end

   assign map_out = map_ff;

endmodule

### sv/brs_frame_store.sv
// ============================================================================
// Bilinear resampler frame store
// Source pixels in four banks split by row and column parity, so that the
// four neighbours of a sample are read together.
// ============================================================================
`timescale 1ns / 1ps

module brs_frame_store (
   input  logic                                          clock,
   input  logic                                          en,
   input  logic                                          wr_en,
   input  logic [brs_pkg::XW-1:0]                        wr_col,
   input  logic [brs_pkg::YW-1:0]                        wr_row,
   input  logic [brs_pkg::PIX_W-1:0]                     wr_pixel,
   input  logic [brs_pkg::XW-1:0]                        rd_x0,
   input  logic [brs_pkg::YW-1:0]                        rd_y0,
   output logic [1:0][1:0][brs_pkg::PIX_W-1:0]           rd_data
);
   import brs_pkg::*;

   logic [1:0][XW-2:0]  x_half;
   logic [1:0][YW-2:0]  y_half;
   logic [XW:0]         x_even;
   logic [YW:0]         y_even;
   logic [BANK_AW-1:0]  wr_addr;

   // The even neighbour is the next even index at or above the base, the odd
   // neighbour the odd index at or above it; the bank that is not
   // needed at the right or bottom edge reads a don't-care address.
   assign x_even    = (XW+1)'(rd_x0) + (XW+1)'(rd_x0[0]);
   assign y_even    = (YW+1)'(rd_y0) + (YW+1)'(rd_y0[0]);
   assign x_half[0] = x_even[XW-1:1];
   assign x_half[1] = rd_x0[XW-1:1];
   assign y_half[0] = y_even[YW-1:1];
   assign y_half[1] = rd_y0[YW-1:1];
   assign wr_addr   = {wr_row[YW-1:1], wr_col[XW-1:1]};

   for (genvar py = 0; py < 2; py++) begin : g_row
      for (genvar px = 0; px < 2; px++) begin : g_col
         logic [PIX_W-1:0]   store_ff [BANK_DEPTH];
         logic [PIX_W-1:0]   rd_ff;
         logic [BANK_AW-1:0] rd_addr;

         assign rd_addr = {y_half[py], x_half[px]};

         // One write port and one registered read port per bank.
         always_ff @(posedge clock) begin
            if (en && wr_en && (wr_row[0] == 1'(py)) && (wr_col[0] == 1'(px))) begin
               store_ff[wr_addr] <= wr_pixel;
            end
            if (en) begin
               rd_ff <= store_ff[rd_addr];
            end
         end

         assign rd_data[py][px] = rd_ff;
      end
   end

endmodule

### sv/brs_lane.sv
// ============================================================================
// Bilinear resampler channel lane
// Interpolates one byte channel from its four neighbours in two stages:
// horizontally, then vertically, truncating to a byte.
// ============================================================================
`timescale 1ns / 1ps

module brs_lane (
   input  logic                            clock,
   input  logic                            en,
   input  brs_pkg::corners_type            corners,
   input  logic [brs_pkg::FRAC_BITS-1:0]   frac_x,
   input  logic [brs_pkg::FRAC_BITS-1:0]   frac_y,
   output logic [brs_pkg::CHAN_W-1:0]      chan_out
);
   import brs_pkg::*;

   logic [WT_W-1:0]             wx0;
   logic [WT_W-1:0]             wx1;
   logic [WT_W-1:0]             wy0;
   logic [WT_W-1:0]             wy1;
   logic [UP_W-1:0]             upper_ff;
   logic [UP_W-1:0]             upper_in;
   logic [UP_W-1:0]             lower_ff;
   logic [UP_W-1:0]             lower_in;
   logic [FRAC_BITS-1:0]        fy_ff;
   logic [SUM_W-1:0]            sum;
   logic [SUM_W-2*FRAC_BITS-1:0] whole;
   logic [CHAN_W-1:0]           chan_ff;
   logic [CHAN_W-1:0]           chan_in;

   // Horizontal pass on the upper and lower rows.
   assign wx1 = WT_W'(frac_x);
   assign wx0 = WT_W'(ONE) - wx1;
   assign upper_in = UP_W'((UP_W+1)'(corners.c00) * (UP_W+1)'(wx0)
                         + (UP_W+1)'(corners.c10) * (UP_W+1)'(wx1));
   assign lower_in = UP_W'((UP_W+1)'(corners.c01) * (UP_W+1)'(wx0)
                         + (UP_W+1)'(corners.c11) * (UP_W+1)'(wx1));

   // Vertical pass and truncation to a byte.
   assign wy1   = WT_W'(fy_ff);
   assign wy0   = WT_W'(ONE) - wy1;
   assign sum   = SUM_W'(upper_ff) * SUM_W'(wy0) + SUM_W'(lower_ff) * SUM_W'(wy1);
   assign whole = sum[SUM_W-1:2*FRAC_BITS];
   assign chan_in = (whole > (SUM_W-2*FRAC_BITS)'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX)
                                                             : CHAN_W'(whole);

   always_ff @(posedge clock) begin
      if (en) begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
         fy_ff    <= frac_y;
         chan_ff  <= chan_in;
      end
   end

   assign chan_out = chan_ff;

endmodule

### verif/bilinear_resampler_checker.sv
// ============================================================================
// Bilinear resampler checker
// Watches the request, result and register ports of the resampler. It keeps
// its own copy of the source image and of the four size registers, works out
// the interpolated pixel for every sample item taken, and compares each result
// item taken against the oldest pixel still awaited.
// ============================================================================
`timescale 1ns / 1ps

module bilinear_resampler_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // col [7:0], row [15:8], pixel_in [39:16]
   input  logic [brs_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type [0]
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pixel_out [23:0], out_col [31:24], out_row [39:32]
   input  logic [brs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  brs_pkg::csr_index_type         csr_index,
   input  logic [brs_pkg::SIZE_W-1:0]     csr_wdata,
   output logic [31:0]                    fail_count,
   output logic [31:0]                    pending
);
   import brs_pkg::*;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } output_pixel_type;

   logic [PIX_W-1:0]  source_image [0:MAX_WIDTH*MAX_HEIGHT-1];
   logic [SIZE_W-1:0] src_cols, src_rows, dst_cols, dst_rows;
   output_pixel_type  awaited_pixels [$];
   int                mismatches = 0;

   assign fail_count = mismatches;

   // Maps a destination position onto a source index, its neighbour clamped
   // to the edge, and the fraction between the two.
   function automatic void locate_source(input logic [POS_W-1:0] pos,
                                         input logic [SIZE_W-1:0] src_size,
                                         input logic [SIZE_W-1:0] dst_size,
                                         input int limit,
                                         output int base, output int next,
                                         output int frac);
      int s;
      int d;
      int g;
      int last;
      s = (src_size == 0) ? 1 : ((int'(src_size) > limit) ? limit : int'(src_size));
      d = (dst_size == 0) ? 1 : int'(dst_size);
      g = ((int'(pos) * s) << FRAC_BITS) / d - HALF;
      last = (s - 1) << FRAC_BITS;
      // A negative coordinate sits on the first pixel with no fraction.
      if (g < 0) g = 0;
      if (g > last) g = last;
      base = g >> FRAC_BITS;
      frac = g & (ONE - 1);
      next = (base + 1 < s) ? base + 1 : s - 1;
   endfunction

   // Interpolates the three byte channels at one destination position.
   function automatic logic [PIX_W-1:0] resample_pixel(input logic [POS_W-1:0] col,
                                                       input logic [POS_W-1:0] row);
      int x0, x1, tx, y0, y1, ty;
      int a, b, c, d, upper, lower, total;
      logic [PIX_W-1:0] p00, p10, p01, p11, result;
      locate_source(col, src_cols, dst_cols, MAX_WIDTH, x0, x1, tx);
      locate_source(row, src_rows, dst_rows, MAX_HEIGHT, y0, y1, ty);
      p00 = source_image[y0 * MAX_WIDTH + x0];
      p10 = source_image[y0 * MAX_WIDTH + x1];
      p01 = source_image[y1 * MAX_WIDTH + x0];
      p11 = source_image[y1 * MAX_WIDTH + x1];
      result = '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         a = int'(p00[CHAN_W*ch +: CHAN_W]);
         b = int'(p10[CHAN_W*ch +: CHAN_W]);
         c = int'(p01[CHAN_W*ch +: CHAN_W]);
         d = int'(p11[CHAN_W*ch +: CHAN_W]);
         upper = a * (ONE - tx) + b * tx;
         lower = c * (ONE - tx) + d * tx;
         total = (upper * (ONE - ty) + lower * ty) >> (2 * FRAC_BITS);
         if (total > CHAN_MAX) total = CHAN_MAX;
         result[CHAN_W*ch +: CHAN_W] = total[CHAN_W-1:0];
      end
      return result;
   endfunction

   always @(posedge clock) begin
      output_pixel_type want;
      if (reset) begin
         // Sizes after reset: 256 x 256 source, 28 x 28 output.
         src_cols = 9'd256;
         src_rows = 9'd256;
         dst_cols = 9'd28;
         dst_rows = 9'd28;
         awaited_pixels.delete();
      end else begin
         // Register writes.
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_cols = csr_wdata;
               CSR_SRC_HEIGHT: src_rows = csr_wdata;
               CSR_DST_WIDTH:  dst_cols = csr_wdata;
               CSR_DST_HEIGHT: dst_rows = csr_wdata;
               default: ;
            endcase
         end

         // A load item updates the image copy; a sample item queues a pixel.
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_LOAD) begin
               source_image[req_tdata[15:0]] = req_tdata[39:16];
            end else begin
               want.pixel = resample_pixel(req_tdata[7:0], req_tdata[15:8]);
               want.col   = req_tdata[7:0];
               want.row   = req_tdata[15:8];
               awaited_pixels.push_back(want);
            end
         end

         // Each result item is matched against the oldest awaited pixel.
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_pixels.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_pixels.pop_front();
               if (rsp_tdata[23:0] !== want.pixel) begin
                  $display("%0t: pixel_out mismatch at (%0d,%0d), expected %h, actual %h",
                           $time, want.col, want.row, want.pixel, rsp_tdata[23:0]);
                  mismatches++;
               end
               if (rsp_tdata[31:24] !== want.col) begin
                  $display("%0t: out_col mismatch, expected %0d, actual %0d",
                           $time, want.col, rsp_tdata[31:24]);
                  mismatches++;
               end
               if (rsp_tdata[39:32] !== want.row) begin
                  $display("%0t: out_row mismatch, expected %0d, actual %0d",
                           $time, want.row, rsp_tdata[39:32]);
                  mismatches++;
               end
            end
         end
      end
      pending <= awaited_pixels.size();
   end

endmodule

### verif/bilinear_image_resampler_top_tb.sv
// ============================================================================
// Bilinear image resampler testbench
// Works with source images of many shapes, from one pixel up to full-width
// and full-height strips, loading each source pixel before the first sample
// that reads it, and requests output pixels under a series of size settings,
// including zero and oversized register values. Both streams idle at random;
// a separate checker predicts and compares every result item.
// ============================================================================
`timescale 1ns / 1ps

module bilinear_image_resampler_top_tb;
   import brs_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 24;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   csr_index_type         csr_index  = CSR_SRC_WIDTH;
   logic [SIZE_W-1:0]     csr_wdata  = '0;
   logic [31:0]           fail_count;
   logic [31:0]           pending;
   bit                    steady     = 1'b0;
   bit                    loaded_map [0:MAX_WIDTH*MAX_HEIGHT-1];
   int                    idle_cycles = 0;
   // Sizes as last written, used to find the source pixels a sample reads.
   int                    cur_src_w  = 256;
   int                    cur_src_h  = 256;
   int                    cur_dst_w  = 28;
   int                    cur_dst_h  = 28;

   bilinear_image_resampler_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bilinear_resampler_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The result side stalls now and then, except during steady stretches.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 9);
   end

   // Watchdog: too long without any item moving ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL bilinear_image_resampler_top");
            $finish;
         end
      end
   end

   // Sizes beyond the store count as its full size, zero counts as one.
   function automatic int clamp_size(input int v, input int limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   // Source index and its edge-clamped neighbour for one destination position.
   function automatic void source_span(input int pos, input int src, input int dst,
                                       input int limit, output int i0, output int i1);
      int s;
      int d;
      int g;
      s = clamp_size(src, limit);
      d = (dst == 0) ? 1 : dst;
      g = ((pos * s) << FRAC_BITS) / d - HALF;
      if (g < 0) g = 0;
      if (g > ((s - 1) << FRAC_BITS)) g = (s - 1) << FRAC_BITS;
      i0 = g >> FRAC_BITS;
      i1 = (i0 + 1 < s) ? i0 + 1 : s - 1;
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return {PIX_W{1'b1}};
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Offers one item, with the odd random gap first, and waits until taken.
   task automatic push_request(input req_kind_type kind, input logic [POS_W-1:0] col,
                               input logic [POS_W-1:0] row, input logic [PIX_W-1:0] pix);
      while (!steady && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {pix, row, col};
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_LOAD) loaded_map[{row, col}] = 1'b1;
   endtask

   // Loads one source pixel unless it has been written already.
   task automatic load_missing(input int c, input int r);
      if (!loaded_map[r * MAX_WIDTH + c])
         push_request(REQ_LOAD, POS_W'(c), POS_W'(r), random_pixel());
   endtask

   // Requests one output pixel after making sure its four source pixels are
   // in the store, so that no sample ever reads an empty store entry.
   task automatic push_sample(input logic [POS_W-1:0] col, input logic [POS_W-1:0] row);
      int x0, x1, y0, y1;
      source_span(int'(col), cur_src_w, cur_dst_w, MAX_WIDTH, x0, x1);
      source_span(int'(row), cur_src_h, cur_dst_h, MAX_HEIGHT, y0, y1);
      load_missing(x0, y0);
      load_missing(x1, y0);
      load_missing(x0, y1);
      load_missing(x1, y1);
      push_request(REQ_SAMPLE, col, row, PIX_W'($urandom));
   endtask

   // Holds the sender until every awaited result is back and any trailing
   // loads have left the pipeline.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sizes(input int sw, input int sh, input int dw, input int dh,
                              input bit src_only);
      cur_src_w = sw;
      cur_src_h = sh;
      csr_we    <= 1'b1;
      csr_index <= CSR_SRC_WIDTH;
      csr_wdata <= sw[SIZE_W-1:0];
      @(posedge clock);
      csr_index <= CSR_SRC_HEIGHT;
      csr_wdata <= sh[SIZE_W-1:0];
      @(posedge clock);
      if (!src_only) begin
         cur_dst_w = dw;
         cur_dst_h = dh;
         csr_index <= CSR_DST_WIDTH;
         csr_wdata <= dw[SIZE_W-1:0];
         @(posedge clock);
         csr_index <= CSR_DST_HEIGHT;
         csr_wdata <= dh[SIZE_W-1:0];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // One size setting: write the registers, then a random mix of loads and
   // samples, mostly inside the output frame.
   task automatic run_phase(input int sw, input int sh, input int dw, input int dh,
                            input int n_items, input bit calm);
      int w, h, dwr, dhr, pick;
      drain_pipeline();
      write_sizes(sw, sh, dw, dh, 1'b0);
      steady <= calm;
      w   = clamp_size(sw, MAX_WIDTH);
      h   = clamp_size(sh, MAX_HEIGHT);
      dwr = clamp_size(dw, MAX_WIDTH);
      dhr = clamp_size(dh, MAX_HEIGHT);
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(99);
         if (pick < 2)
            drain_pipeline();
         else if (pick < 12)
            push_request(REQ_LOAD, POS_W'($urandom_range(255)), POS_W'($urandom_range(255)),
                         random_pixel());
         else if (pick < 35)
            push_request(REQ_LOAD, POS_W'($urandom_range(w - 1)), POS_W'($urandom_range(h - 1)),
                         random_pixel());
         else if (pick < 85)
            push_sample(POS_W'($urandom_range(dwr - 1)), POS_W'($urandom_range(dhr - 1)));
         else
            push_sample(POS_W'($urandom_range(255)), POS_W'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: a 4 x 3 checkerboard of black and white pixels, the
      // output size left at its reset value of 28 x 28.
      write_sizes(4, 3, 0, 0, 1'b1);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            push_request(REQ_LOAD, c[POS_W-1:0], r[POS_W-1:0],
                         ((r + c) % 2 == 1) ? 24'hFFFFFF : 24'h000000);
         end
      end
      push_request(REQ_LOAD, 8'd255, 8'd255, 24'hFFFFFF);
      // First pixel, where the source coordinate is negative.
      push_request(REQ_SAMPLE, 8'd0, 8'd0, 24'h000000);
      push_request(REQ_SAMPLE, 8'd1, 8'd1, 24'hFFFFFF);
      push_request(REQ_SAMPLE, 8'd13, 8'd14, 24'h000000);
      push_request(REQ_SAMPLE, 8'd27, 8'd27, 24'hFFFFFF);
      // Positions past the output frame saturate at the last source pixel.
      push_request(REQ_SAMPLE, 8'd255, 8'd0, 24'h000000);
      push_request(REQ_SAMPLE, 8'd0, 8'd255, 24'h000000);
      push_request(REQ_SAMPLE, 8'd255, 8'd255, 24'hFFFFFF);

      // Size extremes, then shrinking and enlarging, then random shapes.
      run_phase(256, 2, 256, 4, 20, 1'b0);
      run_phase(1, 1, 1, 1, 10, 1'b0);
      run_phase(0, 0, 0, 0, 10, 1'b0);
      run_phase(2, 256, 3, 256, 20, 1'b0);
      run_phase(511, 1, 511, 5, 15, 1'b0);
      run_phase(16, 16, 256, 256, 30, 1'b1);
      run_phase(64, 8, 5, 3, 15, 1'b0);
      for (int p = 0; p < 4; p++) begin
         run_phase($urandom_range(1, 20), $urandom_range(1, 20),
                   $urandom_range(1, 40), $urandom_range(1, 40), 15, 1'b0);
      end

      drain_pipeline();
      if (fail_count == 0) begin
         $display("PASS bilinear_image_resampler_top");
      end else begin
         $display("FAIL bilinear_image_resampler_top");
      end
      $finish;
   end

endmodule

### filelist.f
sv/brs_pkg.sv
sv/brs_axis_map.sv
sv/brs_frame_store.sv
sv/brs_lane.sv
sv/bilinear_image_resampler_top.sv
verif/bilinear_resampler_checker.sv
verif/bilinear_image_resampler_top_tb.sv
